### design/small_table_bubble_sorter_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the small table bubble sorter
// Short forms for clocked checks with a synchronous reset that masks them.
// ----------------------------------------------------------------------------
`ifndef SMALL_TABLE_BUBBLE_SORTER_ASSERT_SVH
`define SMALL_TABLE_BUBBLE_SORTER_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define SBS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that the consequent holds in the cycle after the antecedent
`define SBS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/sbs_pkg.sv
// ----------------------------------------------------------------------------
// sbs_pkg
// Shared types and constants of the small table bubble sorter.
// ----------------------------------------------------------------------------
package sbs_pkg;

   // Default number of table entries
   localparam int TABLE_DEPTH_DEFAULT = 16;

   // Width of one tooth count
   localparam int VALUE_WIDTH = 8;

   // Input transaction
   typedef struct packed {
      logic [VALUE_WIDTH-1:0] tooth_count;
      logic                   end_of_set;
   } req_type;

   // Result transaction
   typedef struct packed {
      logic [VALUE_WIDTH-1:0] sorted_value;
      logic                   final_value;
      logic                   overflowed;
   } rsp_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_LOAD,
      ST_PASS_RD0,
      ST_PASS_FIRST,
      ST_PASS_CMP,
      ST_PASS_END,
      ST_EMIT
   } state_type;

endpackage

### design/sbs_ram.sv
// ----------------------------------------------------------------------------
// sbs_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module sbs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write the addressed entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Register the read data, hold it between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/small_table_bubble_sorter.sv
// ----------------------------------------------------------------------------
// small_table_bubble_sorter
// Collects a set of tooth counts, bubble-sorts it in a RAM and streams it out.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel (valid/stall): one tooth count per transaction; end_of_set
//    marks the last value of a set. Accepted values go straight to the
//    table; values beyond TABLE_DEPTH are dropped, results carry overflowed.
//  - After the end-of-set transaction req_stall stays high while the table
//    is sorted and emitted. Each bubble pass reads the first entry, compares
//    the carried value with each following entry, writes back one and carries
//    the other, then parks the carry at the top of the span; passes stop
//    early once no swap occurs. The single read port reads one entry per cycle.
//  - rsp channel (valid/stall): one result per stored value, in sorted order,
//    final_value on the last; the next entry is read once the output register
//    frees, and a stall on rsp holds it and the emission sequencer.
//  - The req channel reopens in the cycle the final result appears in the output
//    register, so a new set can load while that result still waits.
//  - csr channel: one bit, descending; write it only while the block is idle.
//  - Reset clears sequencer, count, direction and ovf/pend/swap/valid flags;
//    the table contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module small_table_bubble_sorter #(
   parameter int TABLE_DEPTH = sbs_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  sbs_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output sbs_pkg::rsp_type rsp_data,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic            csr_data
);

   localparam int ADDR_W  = $clog2(TABLE_DEPTH);
   localparam int COUNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int VAL_W   = sbs_pkg::VALUE_WIDTH;
   localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(TABLE_DEPTH);

   sbs_pkg::state_type state_ff, state_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               ovf_ff, ovf_in;
   logic               desc_ff;
   logic [ADDR_W-1:0]  span_ff, span_in;
   logic [ADDR_W-1:0]  idx_ff, idx_in;
   logic [VAL_W-1:0]   carry_ff, carry_in;
   logic               swapped_ff, swapped_in;
   logic               pend_ff, pend_in;
   logic               pend_final_ff, pend_final_in;
   logic               rsp_valid_ff, rsp_valid_in;
   sbs_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [VAL_W-1:0]   wr_data;
   logic               rd_en;
   logic [ADDR_W-1:0]  rd_addr;
   logic [VAL_W-1:0]   rd_data;

   logic               req_acc;
   logic               out_of_order;
   logic [COUNT_W-1:0] set_size;

   // Table of stored values
   sbs_ram #(
      .WIDTH (VAL_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_stall = (state_ff != sbs_pkg::ST_LOAD);
   assign req_acc   = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Compare the carried value with the entry just read
   assign out_of_order = desc_ff ? (carry_ff < rd_data) : (carry_ff > rd_data);

   // Size of the set once the current transaction is counted
   assign set_size = (count_ff == FULL_COUNT) ? count_ff : count_ff + COUNT_W'(1);

   // Sequence loading, bubble passes and emission
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      ovf_in        = ovf_ff;
      span_in       = span_ff;
      idx_in        = idx_ff;
      carry_in      = carry_ff;
      swapped_in    = swapped_ff;
      pend_in       = pend_ff;
      pend_final_in = pend_final_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_data       = carry_ff;
      rd_en         = 1'b0;
      rd_addr       = '0;

      // Drop the output transaction once taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         sbs_pkg::ST_LOAD: begin
            if (req_acc) begin
               if (count_ff != FULL_COUNT) begin
                  wr_en    = 1'b1;
                  wr_addr  = count_ff[ADDR_W-1:0];
                  wr_data  = req_data.tooth_count;
                  count_in = count_ff + COUNT_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_data.end_of_set) begin
                  idx_in = '0;
                  if (set_size >= COUNT_W'(2)) begin
                     span_in  = ADDR_W'(set_size - COUNT_W'(1));
                     state_in = sbs_pkg::ST_PASS_RD0;
                  end else begin
                     state_in = sbs_pkg::ST_EMIT;
                  end
               end
            end
         end

         sbs_pkg::ST_PASS_RD0: begin
            // Open a pass at the first entry
            rd_en      = 1'b1;
            rd_addr    = '0;
            swapped_in = 1'b0;
            state_in   = sbs_pkg::ST_PASS_FIRST;
         end

         sbs_pkg::ST_PASS_FIRST: begin
            carry_in = rd_data;
            rd_en    = 1'b1;
            rd_addr  = ADDR_W'(1);
            idx_in   = '0;
            state_in = sbs_pkg::ST_PASS_CMP;
         end

         sbs_pkg::ST_PASS_CMP: begin
            // Write back the smaller (or larger) pair member, carry the other
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            if (out_of_order) begin
               wr_data    = rd_data;
               swapped_in = 1'b1;
            end else begin
               wr_data  = carry_ff;
               carry_in = rd_data;
            end
            if ((idx_ff + ADDR_W'(1)) < span_ff) begin
               rd_en   = 1'b1;
               rd_addr = idx_ff + ADDR_W'(1) + ADDR_W'(1);
               idx_in  = idx_ff + ADDR_W'(1);
            end else begin
               state_in = sbs_pkg::ST_PASS_END;
            end
         end

         sbs_pkg::ST_PASS_END: begin
            // Park the carried value at the top of the span
            wr_en   = 1'b1;
            wr_addr = span_ff;
            wr_data = carry_ff;
            idx_in  = '0;
            if (swapped_ff && (span_ff > ADDR_W'(1))) begin
               span_in  = span_ff - ADDR_W'(1);
               state_in = sbs_pkg::ST_PASS_RD0;
            end else begin
               state_in = sbs_pkg::ST_EMIT;
            end
         end

         sbs_pkg::ST_EMIT: begin
            if (pend_ff) begin
               // Load the output register with the entry read last cycle
               rsp_valid_in             = 1'b1;
               rsp_data_in.sorted_value = rd_data;
               rsp_data_in.final_value  = pend_final_ff;
               rsp_data_in.overflowed   = ovf_ff;
               pend_in                  = 1'b0;
               if (pend_final_ff) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
                  state_in = sbs_pkg::ST_LOAD;
               end
            end else if (!rsp_valid_ff || !rsp_stall) begin
               // Read the next entry while the output register frees up
               rd_en         = 1'b1;
               rd_addr       = idx_ff;
               pend_in       = 1'b1;
               pend_final_in = ((COUNT_W'(idx_ff) + COUNT_W'(1)) == count_ff);
               idx_in        = idx_ff + ADDR_W'(1);
            end
         end

         default: begin
            state_in = sbs_pkg::ST_LOAD;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sbs_pkg::ST_LOAD;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         swapped_ff   <= 1'b0;
         desc_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         swapped_ff   <= swapped_in;
         if (csr_valid && csr_ready) begin
            desc_ff <= csr_data;
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      span_ff       <= span_in;
      idx_ff        <= idx_in;
      carry_ff      <= carry_in;
      pend_final_ff <= pend_final_in;
      rsp_data_ff   <= rsp_data_in;
   end

endmodule

### design/sbs_checker.sv
// ----------------------------------------------------------------------------
// sbs_checker
// Port-level checks on result order, set framing, stall hold and overflow.
// ----------------------------------------------------------------------------
`include "small_table_bubble_sorter_assert.svh"

module sbs_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input sbs_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input sbs_pkg::rsp_type rsp_data,
   input logic             csr_valid,
   input logic             csr_ready,
   input logic             csr_data
);

   logic                            end_acc;
   logic                            rsp_acc;
   logic                            final_acc;
   logic [1:0]                      open_ff;
   logic                            mid_ff;
   logic                            desc_ff;
   logic [sbs_pkg::VALUE_WIDTH-1:0] prev_value_ff;
   logic                            prev_ovf_ff;
   logic                            order_ok;

   assign end_acc   = req_valid && !req_stall && req_data.end_of_set;
   assign rsp_acc   = rsp_valid && !rsp_stall;
   assign final_acc = rsp_acc && rsp_data.final_value;
   assign order_ok  = desc_ff ? (rsp_data.sorted_value <= prev_value_ff)
                              : (rsp_data.sorted_value >= prev_value_ff);

   // Count open sets, track position within a set and the direction bit
   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= 2'd0;
         mid_ff  <= 1'b0;
         desc_ff <= 1'b0;
      end else begin
         if (end_acc && !final_acc) begin
            open_ff <= open_ff + 2'd1;
         end else if (!end_acc && final_acc) begin
            open_ff <= open_ff - 2'd1;
         end
         if (rsp_acc) begin
            mid_ff <= !rsp_data.final_value;
         end
         if (csr_valid && csr_ready) begin
            desc_ff <= csr_data;
         end
      end
   end

   // Hold the last accepted result
   always_ff @(posedge clock) begin
      if (rsp_acc) begin
         prev_value_ff <= rsp_data.sorted_value;
         prev_ovf_ff   <= rsp_data.overflowed;
      end
   end

   `SBS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
                    rsp_valid && $stable(rsp_data), "stalled result changed")

   `SBS_ASSERT_SAME(a_rsp_in_set, clock, reset, rsp_valid, open_ff != 2'd0,
                    "result without an open set")

   `SBS_ASSERT_SAME(a_rsp_order, clock, reset, rsp_acc && mid_ff, order_ok,
                    "results out of sorted order")

   `SBS_ASSERT_SAME(a_rsp_ovf, clock, reset, rsp_acc && mid_ff,
                    rsp_data.overflowed == prev_ovf_ff, "overflow flag changed within set")

endmodule

bind small_table_bubble_sorter sbs_checker u_sbs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data),
   .csr_valid (csr_valid),
   .csr_ready (csr_ready),
   .csr_data  (csr_data)
);
